@@ src/rcls_pkg.sv @@
`default_nettype none
package rcls_pkg;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_PACKET = 2'd1;
   localparam logic [1:0] CMD_BEEP   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BEEP_ON   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BEEP_GAP  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BEEP_STRT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RX_ENABLE = 3'd5;

   localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
   localparam logic [9:0]  PERIOD_RESET     = 10'd100;
   localparam logic [9:0]  BEEP_ON_RESET    = 10'd100;
   localparam logic [9:0]  BEEP_GAP_RESET   = 10'd150;
   localparam logic [9:0]  BEEP_START_RESET = 10'd50;

   localparam logic [11:0] CH_CENTRE       = 12'd2048;
   localparam logic [7:0]  LINK_UP_BEEPS   = 8'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] payload_byte0;
      logic [7:0] payload_byte1;
      logic [7:0] payload_byte2;
      logic [7:0] payload_byte3;
      logic [7:0] payload_byte4;
      logic [7:0] payload_byte5;
      logic [7:0] payload_byte6;
      logic [7:0] payload_byte7;
      logic [7:0] payload_byte8;
      logic [7:0] payload_byte9;
      logic [7:0] beep_request_count;
   } req_type;

   typedef struct packed {
      logic [11:0] channel_one;
      logic [11:0] channel_two;
      logic [11:0] channel_three;
      logic [11:0] channel_four;
      logic [7:0]  aux_one;
      logic [7:0]  aux_two;
      logic        buzzer_drive;
      logic        link_up;
      logic        link_timed_out;
      logic        ever_received;
      logic [31:0] packets_total;
      logic [31:0] packets_lost;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [9:0]  status_period_ms;
      logic [9:0]  beep_on_ms;
      logic [9:0]  beep_gap_ms;
      logic [9:0]  beep_start_ms;
      logic        receiver_enabled;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/rc_link_supervisor.sv @@
`default_nettype none
// Radio link supervisor. Each transaction (millisecond tick, received payload or beep
// request) yields one status transaction carrying a snapshot of channels, aux bytes,
// buzzer, link flags and packet counters after that item. One transaction is taken
// every clock cycle while the result is not stalled; the input register and the result
// register sit around the state update. Configuration writes take effect at
// once and should only be made while no transaction is in flight.
module rc_link_supervisor
   import rcls_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_payload,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic    req_valid_ff;
   req_type req_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff;
   cfg_type cfg_ff;
   rsp_type result;
   logic    advance;
   logic    fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_item_ff <= req_payload;
      end
      if (fire) begin
         rsp_payload_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms       <= TIMEOUT_RESET;
         cfg_ff.status_period_ms <= PERIOD_RESET;
         cfg_ff.beep_on_ms       <= BEEP_ON_RESET;
         cfg_ff.beep_gap_ms      <= BEEP_GAP_RESET;
         cfg_ff.beep_start_ms    <= BEEP_START_RESET;
         cfg_ff.receiver_enabled <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TIMEOUT:   cfg_ff.timeout_ms       <= csr_write_data;
            REG_PERIOD:    cfg_ff.status_period_ms <= csr_write_data[9:0];
            REG_BEEP_ON:   cfg_ff.beep_on_ms       <= csr_write_data[9:0];
            REG_BEEP_GAP:  cfg_ff.beep_gap_ms      <= csr_write_data[9:0];
            REG_BEEP_STRT: cfg_ff.beep_start_ms    <= csr_write_data[9:0];
            REG_RX_ENABLE: cfg_ff.receiver_enabled <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   rcls_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (req_item_ff),
      .cfg   (cfg_ff),
      .result(result)
   );

endmodule
`default_nettype wire

@@ src/rcls_core.sv @@
`default_nettype none
module rcls_core
   import rcls_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [TIME_BITS-1:0] time_now_ff, time_now_in;
   logic [TIME_BITS-1:0] last_update_ff, last_update_in;
   logic [TIME_BITS-1:0] last_packet_ff, last_packet_in;
   logic [TIME_BITS-1:0] next_beep_ff, next_beep_in;
   logic                 beep_active_ff, beep_active_in;
   logic                 beep_on_ff, beep_on_in;
   logic [7:0]           beeps_wanted_ff, beeps_wanted_in;
   logic [7:0]           beeps_done_ff, beeps_done_in;
   logic                 link_up_ff, link_up_in;
   logic                 timed_out_ff, timed_out_in;
   logic                 ever_ff, ever_in;
   logic [11:0]          channel_ff [4];
   logic [11:0]          channel_in [4];
   logic [7:0]           aux_ff [2];
   logic [7:0]           aux_in [2];
   logic [31:0]          total_ff, total_in;
   logic [31:0]          lost_ff, lost_in;

   logic [TIME_BITS-1:0] tick_time;
   logic [TIME_BITS-1:0] update_diff;
   logic [TIME_BITS-1:0] beep_diff;
   logic [TIME_BITS-1:0] timeout_diff;
   logic [7:0]           done_inc;
   logic [11:0]          rx_channel [4];

   function automatic logic [11:0] decode_channel(input logic [7:0] lo, input logic [7:0] hi);
      logic [11:0] value;
      if (hi[7:4] != 4'd0) begin
         value = CH_CENTRE;
      end else begin
         value = {hi[3:0], lo};
      end
      return value;
   endfunction

   assign tick_time    = time_now_ff + TIME_BITS'(1);
   assign update_diff  = tick_time - last_update_ff;
   assign beep_diff    = tick_time - next_beep_ff;
   assign timeout_diff = tick_time - last_packet_ff;
   assign done_inc     = beeps_done_ff + 8'd1;

   assign rx_channel[0] = decode_channel(item.payload_byte0, item.payload_byte1);
   assign rx_channel[1] = decode_channel(item.payload_byte2, item.payload_byte3);
   assign rx_channel[2] = decode_channel(item.payload_byte4, item.payload_byte5);
   assign rx_channel[3] = decode_channel(item.payload_byte6, item.payload_byte7);

   always_comb begin
      time_now_in     = time_now_ff;
      last_update_in  = last_update_ff;
      last_packet_in  = last_packet_ff;
      next_beep_in    = next_beep_ff;
      beep_active_in  = beep_active_ff;
      beep_on_in      = beep_on_ff;
      beeps_wanted_in = beeps_wanted_ff;
      beeps_done_in   = beeps_done_ff;
      link_up_in      = link_up_ff;
      timed_out_in    = timed_out_ff;
      ever_in         = ever_ff;
      channel_in      = channel_ff;
      aux_in          = aux_ff;
      total_in        = total_ff;
      lost_in         = lost_ff;
      case (item.command)
         CMD_TICK: begin
            time_now_in = tick_time;
            if (update_diff >= TIME_BITS'(cfg.status_period_ms)) begin
               last_update_in = tick_time;
               if (beep_active_ff && !beep_diff[TIME_BITS-1]) begin
                  if (!beep_on_ff) begin
                     beep_on_in   = 1'b1;
                     next_beep_in = tick_time + TIME_BITS'(cfg.beep_on_ms);
                  end else begin
                     beep_on_in    = 1'b0;
                     beeps_done_in = done_inc;
                     if (done_inc >= beeps_wanted_ff) begin
                        beep_active_in = 1'b0;
                     end else begin
                        next_beep_in = tick_time + TIME_BITS'(cfg.beep_gap_ms);
                     end
                  end
               end
               if (link_up_ff && (timeout_diff > TIME_BITS'(cfg.timeout_ms))) begin
                  link_up_in   = 1'b0;
                  timed_out_in = 1'b1;
                  lost_in      = lost_ff + 32'd1;
                  for (int i = 0; i < 4; i++) begin
                     channel_in[i] = CH_CENTRE;
                  end
                  aux_in[0] = 8'd0;
                  aux_in[1] = 8'd0;
               end
            end
         end
         CMD_PACKET: begin
            if (cfg.receiver_enabled) begin
               channel_in     = rx_channel;
               aux_in[0]      = item.payload_byte8;
               aux_in[1]      = item.payload_byte9;
               ever_in        = 1'b1;
               total_in       = total_ff + 32'd1;
               last_packet_in = time_now_ff;
               timed_out_in   = 1'b0;
               if (!link_up_ff) begin
                  link_up_in      = 1'b1;
                  beep_active_in  = 1'b1;
                  beeps_wanted_in = LINK_UP_BEEPS;
                  beeps_done_in   = 8'd0;
                  next_beep_in    = time_now_ff + TIME_BITS'(cfg.beep_start_ms);
                  beep_on_in      = 1'b0;
               end
            end
         end
         CMD_BEEP: begin
            beep_active_in  = 1'b1;
            beeps_wanted_in = item.beep_request_count;
            beeps_done_in   = 8'd0;
            next_beep_in    = time_now_ff + TIME_BITS'(cfg.beep_start_ms);
            beep_on_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff     <= '0;
         last_update_ff  <= '0;
         last_packet_ff  <= '0;
         next_beep_ff    <= '0;
         beep_active_ff  <= 1'b0;
         beep_on_ff      <= 1'b0;
         beeps_wanted_ff <= 8'd0;
         beeps_done_ff   <= 8'd0;
         link_up_ff      <= 1'b0;
         timed_out_ff    <= 1'b0;
         ever_ff         <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            channel_ff[i] <= 12'd0;
         end
         aux_ff[0]       <= 8'd0;
         aux_ff[1]       <= 8'd0;
         total_ff        <= 32'd0;
         lost_ff         <= 32'd0;
      end else if (fire) begin
         time_now_ff     <= time_now_in;
         last_update_ff  <= last_update_in;
         last_packet_ff  <= last_packet_in;
         next_beep_ff    <= next_beep_in;
         beep_active_ff  <= beep_active_in;
         beep_on_ff      <= beep_on_in;
         beeps_wanted_ff <= beeps_wanted_in;
         beeps_done_ff   <= beeps_done_in;
         link_up_ff      <= link_up_in;
         timed_out_ff    <= timed_out_in;
         ever_ff         <= ever_in;
         channel_ff      <= channel_in;
         aux_ff          <= aux_in;
         total_ff        <= total_in;
         lost_ff         <= lost_in;
      end
   end

   always_comb begin
      result.channel_one    = channel_in[0];
      result.channel_two    = channel_in[1];
      result.channel_three  = channel_in[2];
      result.channel_four   = channel_in[3];
      result.aux_one        = aux_in[0];
      result.aux_two        = aux_in[1];
      result.buzzer_drive   = beep_on_in;
      result.link_up        = link_up_in;
      result.link_timed_out = timed_out_in;
      result.ever_received  = ever_in;
      result.packets_total  = total_in;
      result.packets_lost   = lost_in;
   end

endmodule
`default_nettype wire

@@ src/rcls_checker.sv @@
`default_nettype none
module rcls_checker
   import rcls_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.link_up |-> rsp_payload.ever_received)
      else $error("link up without any packet");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.link_up && rsp_payload.link_timed_out))
      else $error("link up and timed out together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.link_timed_out |->
         rsp_payload.channel_one == CH_CENTRE && rsp_payload.channel_four == CH_CENTRE &&
         rsp_payload.aux_one == 8'd0 && rsp_payload.aux_two == 8'd0)
      else $error("outputs not recentred after timeout");

endmodule

bind rc_link_supervisor rcls_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
`default_nettype wire

@@ verif/tb_rc_link_supervisor.sv @@
`timescale 1ns / 100ps

module tb_rc_link_supervisor;
   import rcls_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [15:0] CH_LIMIT    = 16'd4095;
   localparam int         CYCLE_LIMIT  = 250000;
   localparam int         RANDOM_ITEMS = 1950;
   localparam int         PHASES       = 10;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         PRINT_CAP    = 40;

   class link_status_board;
      cfg_type     cfg;
      logic [31:0] now_ms, last_status_ms, last_rx_ms, beep_due_ms;
      bit          beeping, sound_on, up, timed_out, ever;
      logic [7:0]  beeps_target, beeps_given;
      logic [11:0] chan [4];
      logic [7:0]  aux [2];
      logic [31:0] rx_count, lost_count;
      rsp_type     status_q [$];
      int          mismatches, checked;

      function new();
         cfg.timeout_ms       = TIMEOUT_RESET;
         cfg.status_period_ms = PERIOD_RESET;
         cfg.beep_on_ms       = BEEP_ON_RESET;
         cfg.beep_gap_ms      = BEEP_GAP_RESET;
         cfg.beep_start_ms    = BEEP_START_RESET;
         cfg.receiver_enabled = 1'b1;
         now_ms = '0; last_status_ms = '0; last_rx_ms = '0; beep_due_ms = '0;
         beeping = 0; sound_on = 0; up = 0; timed_out = 0; ever = 0;
         beeps_target = '0; beeps_given = '0;
         for (int i = 0; i < 4; i++) chan[i] = '0;
         aux[0] = '0; aux[1] = '0;
         rx_count = '0; lost_count = '0;
         mismatches = 0; checked = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_TIMEOUT:   cfg.timeout_ms       = data;
            REG_PERIOD:    cfg.status_period_ms = data[9:0];
            REG_BEEP_ON:   cfg.beep_on_ms       = data[9:0];
            REG_BEEP_GAP:  cfg.beep_gap_ms      = data[9:0];
            REG_BEEP_STRT: cfg.beep_start_ms    = data[9:0];
            REG_RX_ENABLE: cfg.receiver_enabled = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function void arm_beeper(logic [7:0] count);
         beeping      = 1;
         beeps_target = count;
         beeps_given  = '0;
         beep_due_ms  = now_ms + cfg.beep_start_ms;
         sound_on     = 0;
      endfunction

      function void step_beeper();
         logic [31:0] lag;
         if (!beeping) return;
         lag = now_ms - beep_due_ms;
         if (lag[31]) return;
         if (!sound_on) begin
            sound_on    = 1;
            beep_due_ms = now_ms + cfg.beep_on_ms;
         end else begin
            sound_on    = 0;
            beeps_given = beeps_given + 8'd1;
            if (beeps_given >= beeps_target) beeping = 0;
            else beep_due_ms = now_ms + cfg.beep_gap_ms;
         end
      endfunction

      function void tick();
         logic [31:0] since;
         now_ms = now_ms + 32'd1;
         since  = now_ms - last_status_ms;
         if (since < cfg.status_period_ms) return;
         last_status_ms = now_ms;
         step_beeper();
         since = now_ms - last_rx_ms;
         if (up && since > cfg.timeout_ms) begin
            up         = 0;
            timed_out  = 1;
            lost_count = lost_count + 32'd1;
            for (int i = 0; i < 4; i++) chan[i] = CH_CENTRE;
            aux[0] = '0;
            aux[1] = '0;
         end
      endfunction

      function logic [11:0] channel_of(logic [7:0] lo, logic [7:0] hi);
         logic [15:0] v;
         v = {hi, lo};
         return (v > CH_LIMIT) ? CH_CENTRE : v[11:0];
      endfunction

      function void take_packet(req_type r);
         if (!cfg.receiver_enabled) return;
         chan[0] = channel_of(r.payload_byte0, r.payload_byte1);
         chan[1] = channel_of(r.payload_byte2, r.payload_byte3);
         chan[2] = channel_of(r.payload_byte4, r.payload_byte5);
         chan[3] = channel_of(r.payload_byte6, r.payload_byte7);
         aux[0]     = r.payload_byte8;
         aux[1]     = r.payload_byte9;
         ever       = 1;
         rx_count   = rx_count + 32'd1;
         last_rx_ms = now_ms;
         if (!up) begin
            up = 1;
            arm_beeper(LINK_UP_BEEPS);
         end
         timed_out = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type s;
         case (r.command)
            CMD_TICK:   tick();
            CMD_PACKET: take_packet(r);
            CMD_BEEP:   arm_beeper(r.beep_request_count);
            default: ;
         endcase
         s.channel_one    = chan[0];
         s.channel_two    = chan[1];
         s.channel_three  = chan[2];
         s.channel_four   = chan[3];
         s.aux_one        = aux[0];
         s.aux_two        = aux[1];
         s.buzzer_drive   = sound_on;
         s.link_up        = up;
         s.link_timed_out = timed_out;
         s.ever_received  = ever;
         s.packets_total  = rx_count;
         s.packets_lost   = lost_count;
         status_q.push_back(s);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("status %0d %s got 0x%0h want 0x%0h", checked, name, got, want));
      endtask

      task check_status(rsp_type got);
         rsp_type w;
         if (status_q.size() == 0) begin
            report("status transaction with nothing outstanding");
            return;
         end
         w = status_q.pop_front();
         compare("channel_one", 32'(got.channel_one), 32'(w.channel_one));
         compare("channel_two", 32'(got.channel_two), 32'(w.channel_two));
         compare("channel_three", 32'(got.channel_three), 32'(w.channel_three));
         compare("channel_four", 32'(got.channel_four), 32'(w.channel_four));
         compare("aux_one", 32'(got.aux_one), 32'(w.aux_one));
         compare("aux_two", 32'(got.aux_two), 32'(w.aux_two));
         compare("buzzer_drive", 32'(got.buzzer_drive), 32'(w.buzzer_drive));
         compare("link_up", 32'(got.link_up), 32'(w.link_up));
         compare("link_timed_out", 32'(got.link_timed_out), 32'(w.link_timed_out));
         compare("ever_received", 32'(got.ever_received), 32'(w.ever_received));
         compare("packets_total", got.packets_total, w.packets_total);
         compare("packets_lost", got.packets_lost, w.packets_lost);
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   link_status_board sb;
   int cycle_count = 0;
   int sent = 0;
   int stall_mode = 0;
   int stall_window = 0;

   always #2 clock = ~clock;

   rc_link_supervisor u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: checks each status transaction, stalls in windows of varying density
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_status(rsp_payload);
      if (stall_window == 0) begin
         stall_mode   <= $urandom_range(0, 2);
         stall_window <= $urandom_range(10, 150);
      end else begin
         stall_window <= stall_window - 1;
      end
      case (stall_mode)
         1:       rsp_stall <= ($urandom_range(0, 4) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_item(req_type r);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      logic [CSR_DATA_BITS-1:0] vals [6];
      vals[REG_TIMEOUT]   = c.timeout_ms;
      vals[REG_PERIOD]    = {6'd0, c.status_period_ms};
      vals[REG_BEEP_ON]   = {6'd0, c.beep_on_ms};
      vals[REG_BEEP_GAP]  = {6'd0, c.beep_gap_ms};
      vals[REG_BEEP_STRT] = {6'd0, c.beep_start_ms};
      vals[REG_RX_ENABLE] = {15'd0, c.receiver_enabled};
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_BITS'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
         sb.write_register(CSR_INDEX_BITS'(i), vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type build_packet(logic [15:0] c1, logic [15:0] c2,
                                            logic [15:0] c3, logic [15:0] c4,
                                            logic [7:0] a1, logic [7:0] a2);
      req_type r;
      r.command = CMD_PACKET;
      {r.payload_byte1, r.payload_byte0} = c1;
      {r.payload_byte3, r.payload_byte2} = c2;
      {r.payload_byte5, r.payload_byte4} = c3;
      {r.payload_byte7, r.payload_byte6} = c4;
      r.payload_byte8 = a1;
      r.payload_byte9 = a2;
      r.beep_request_count = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type random_item(bit quiet);
      req_type r;
      int pick;
      logic [7:0] hi [4];
      for (int i = 0; i < 4; i++)
         hi[i] = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 255));
      r = build_packet({hi[0], 8'($urandom_range(0, 255))}, {hi[1], 8'($urandom_range(0, 255))},
                       {hi[2], 8'($urandom_range(0, 255))}, {hi[3], 8'($urandom_range(0, 255))},
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 50) r.beep_request_count = 8'($urandom_range(0, 4));
      pick = $urandom_range(0, 99);
      if (quiet) begin
         if (pick < 92)      r.command = CMD_TICK;
         else if (pick < 98) r.command = CMD_BEEP;
         else                r.command = CMD_UNUSED;
      end else begin
         if (pick < 55)      r.command = CMD_TICK;
         else if (pick < 90) r.command = CMD_PACKET;
         else if (pick < 98) r.command = CMD_BEEP;
         else                r.command = CMD_UNUSED;
      end
      return r;
   endfunction

   function automatic cfg_type settings_for(int p);
      cfg_type c;
      case (p)
         0: c = {16'd1, 10'd1, 10'd1, 10'd1, 10'd0, 1'b1};
         1: c = {16'd65535, 10'd1000, 10'd1000, 10'd1000, 10'd1000, 1'b1};
         2: c = {16'd30, 10'd0, 10'd2, 10'd3, 10'd0, 1'b1};   // status every tick
         3: c = {16'd5, 10'd2, 10'd4, 10'd4, 10'd2, 1'b0};    // receiver off
         default: begin
            c.timeout_ms       = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                                             : 16'($urandom_range(1, 150));
            c.status_period_ms = 10'($urandom_range(1, 10));
            c.beep_on_ms       = 10'($urandom_range(1, 20));
            c.beep_gap_ms      = 10'($urandom_range(1, 20));
            c.beep_start_ms    = 10'($urandom_range(0, 20));
            c.receiver_enabled = ($urandom_range(0, 4) != 0);
         end
      endcase
      return c;
   endfunction

   task automatic run_phase(int count);
      int left, burst, gap;
      bit quiet;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         quiet = ($urandom_range(0, 9) < 3);
         repeat (burst) send_item(random_item(quiet));
         left -= burst;
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 24) == 0) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      req_type r;
      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      rsp_stall        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at reset settings
      r = '1;
      r.command = CMD_UNUSED;
      send_item(r);
      r = '0;
      send_item(r);
      send_item(build_packet(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
      send_item(build_packet(16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 8'hFF, 8'hFF));
      send_item(build_packet(16'h1000, 16'hFFFF, 16'h0800, 16'h8001, 8'h55, 8'hAA));
      r = '0;
      r.command = CMD_BEEP;
      send_item(r);
      r.beep_request_count = 8'hFF;
      send_item(r);
      r = '1;
      r.command = CMD_TICK;
      repeat (3) send_item(r);
      r.command = CMD_BEEP;
      r.beep_request_count = 8'd1;
      send_item(r);
      r = '0;
      repeat (4) send_item(r);
      req_valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         settle();
         apply_settings(settings_for(p));
         @(posedge clock);
         run_phase(RANDOM_ITEMS / PHASES);
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d status transactions never came",
                                                sb.pending()));
      $display("%0d transactions over %0d settings, %0d status compared",
               sent, PHASES + 1, sb.checked);
      $display("%0d packets taken, %0d link losses, %0d mismatches",
               sb.rx_count, sb.lost_count, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
